/* src/integer_to_padded_decimal_text_macros.svh */
// Assertion helpers for the decimal text formatter.
`ifndef INTEGER_TO_PADDED_DECIMAL_TEXT_MACROS_SVH
`define INTEGER_TO_PADDED_DECIMAL_TEXT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ITPDT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define ITPDT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/itpdt_pkg.sv */
`default_nettype none

package itpdt_pkg;

   // Payload widths
   localparam int VALUE_W = 32;
   localparam int COUNT_W = 5;
   localparam int CHAR_W  = 8;
   localparam int POS_W   = 5;

   localparam int MAX_DIGITS_DEFAULT = 16;

   // ASCII codes
   localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
   localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

   // floor(x * RECIP_TEN / 2**RECIP_SHIFT) == x / 10 for any 32-bit x
   localparam logic [VALUE_W-1:0] RECIP_TEN = 32'hCCCCCCCD;
   localparam int RECIP_SHIFT = 35;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic load;
      logic step;
   } ctrl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic out_free;
      logic last;
   } dp_status_type;

endpackage

`default_nettype wire

/* src/itpdt_req_if.sv */
`default_nettype none

interface itpdt_req_if;
   import itpdt_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] value;
   logic [COUNT_W-1:0]        digit_count;
   logic                      sign_mode;

   modport source (output valid, value, digit_count, sign_mode, input ready);
   modport sink   (input valid, value, digit_count, sign_mode, output ready);
endinterface

`default_nettype wire

/* src/itpdt_rsp_if.sv */
`default_nettype none

interface itpdt_rsp_if;
   import itpdt_pkg::*;

   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] character;
   logic [POS_W-1:0]  position;
   logic              final_char;

   modport source (output valid, character, position, final_char, input ready);
   modport sink   (input valid, character, position, final_char, output ready);
endinterface

`default_nettype wire

/* src/itpdt_ctrl.sv */
`default_nettype none

module itpdt_ctrl (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire itpdt_pkg::dp_status_type status,
   output itpdt_pkg::ctrl_cmd_type       cmd
);
   import itpdt_pkg::*;

   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_RUN;
         end
         ST_RUN: begin
            if (status.out_free && status.last) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready = 1'b0;
      cmd.load  = 1'b0;
      cmd.step  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_RUN: begin
            cmd.step = status.out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

/* src/itpdt_datapath.sv */
`default_nettype none

module itpdt_datapath #(
   parameter int MAX_DIGITS = itpdt_pkg::MAX_DIGITS_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire itpdt_pkg::ctrl_cmd_type           cmd,
   output itpdt_pkg::dp_status_type               status,
   input  wire logic signed [itpdt_pkg::VALUE_W-1:0] req_value,
   input  wire logic [itpdt_pkg::COUNT_W-1:0]     req_digit_count,
   input  wire logic                              req_sign_mode,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [itpdt_pkg::CHAR_W-1:0]           rsp_character,
   output logic [itpdt_pkg::POS_W-1:0]            rsp_position,
   output logic                                   rsp_final_char
);
   import itpdt_pkg::*;

   // position counter holds up to MAX_DIGITS (sign position included)
   localparam int CW = $clog2(MAX_DIGITS + 1);
   localparam int WW = (CW > COUNT_W) ? CW : COUNT_W;

   logic [VALUE_W-1:0] mag_ff, mag_in;
   logic               minus_ff, minus_in;
   logic               first_ff, first_in;
   logic [CW-1:0]      pos_ff, pos_in;

   logic              out_valid_ff, out_valid_in;
   logic [CHAR_W-1:0] out_char_ff, out_char_in;
   logic [POS_W-1:0]  out_pos_ff, out_pos_in;
   logic              out_final_ff, out_final_in;

   logic [VALUE_W-1:0]   raw;
   logic [VALUE_W-1:0]   load_mag;
   logic [WW-1:0]        dc_ext;
   logic [WW-1:0]        width_sel;
   logic [CW-1:0]        pos_init;
   logic [2*VALUE_W-1:0] prod;
   logic [VALUE_W-1:0]   quot;
   logic [3:0]           q10_lo;
   logic [3:0]           rem;
   logic [CHAR_W-1:0]    step_char;

   // magnitude and clamped field width of a new item
   always_comb begin
      raw      = req_value;
      load_mag = raw[VALUE_W-1] ? (~raw + VALUE_W'(1)) : raw;
      dc_ext   = WW'(req_digit_count);
      if (dc_ext == '0) begin
         width_sel = WW'(1);
      end else if (dc_ext > WW'(MAX_DIGITS)) begin
         width_sel = WW'(MAX_DIGITS);
      end else begin
         width_sel = dc_ext;
      end
      pos_init = CW'(width_sel - WW'(1) + WW'(req_sign_mode));
   end

   // divide by ten: reciprocal multiply, remainder from the low nibble
   always_comb begin
      prod   = {{VALUE_W{1'b0}}, mag_ff} * {{VALUE_W{1'b0}}, RECIP_TEN};
      quot   = VALUE_W'(prod[2*VALUE_W-1:RECIP_SHIFT]);
      q10_lo = {quot[0], 3'b000} + {quot[2:0], 1'b0};
      rem    = mag_ff[3:0] - q10_lo;
   end

   // character of the current position
   always_comb begin
      if (mag_ff != '0) begin
         step_char = CH_ZERO + {4'd0, rem};
      end else if (first_ff) begin
         step_char = CH_ZERO;
      end else if (minus_ff) begin
         step_char = CH_MINUS;
      end else begin
         step_char = CH_SPACE;
      end
   end

   // work registers
   always_comb begin
      mag_in   = mag_ff;
      minus_in = minus_ff;
      first_in = first_ff;
      pos_in   = pos_ff;
      if (cmd.load) begin
         mag_in   = load_mag;
         minus_in = req_sign_mode & raw[VALUE_W-1];
         first_in = 1'b1;
         pos_in   = pos_init;
      end else if (cmd.step) begin
         first_in = 1'b0;
         pos_in   = pos_ff - CW'(1);
         if (mag_ff != '0) begin
            mag_in = quot;
         end else if (!first_ff) begin
            minus_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      mag_ff   <= mag_in;
      minus_ff <= minus_in;
      first_ff <= first_in;
      pos_ff   <= pos_in;
   end

   // output register
   always_comb begin
      out_valid_in = out_valid_ff & ~rsp_ready;
      out_char_in  = out_char_ff;
      out_pos_in   = out_pos_ff;
      out_final_in = out_final_ff;
      if (cmd.step) begin
         out_valid_in = 1'b1;
         out_char_in  = step_char;
         out_pos_in   = POS_W'(pos_ff);
         out_final_in = (pos_ff == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_char_ff  <= out_char_in;
      out_pos_ff   <= out_pos_in;
      out_final_ff <= out_final_in;
   end

   assign status.out_free = ~out_valid_ff | rsp_ready;
   assign status.last     = (pos_ff == '0);

   assign rsp_valid      = out_valid_ff;
   assign rsp_character  = out_char_ff;
   assign rsp_position   = out_pos_ff;
   assign rsp_final_char = out_final_ff;

endmodule

`default_nettype wire

/* src/integer_to_padded_decimal_text.sv */
// Formats a signed 32-bit number as a right-aligned decimal text field. Each
// item carries the value, a field width (digit_count, clamped to 1..MAX_DIGITS)
// and a sign flag that widens the field by one position and prints '-' for
// negative numbers. The block answers with (clamped width + sign_mode) characters,
// rightmost position first, each tagged with its field position; final_char
// marks position 0. Digits that do not fit are dropped, and the sign with them.
// An item is loaded first, then its characters are produced, paced by the
// divide-by-ten step (a reciprocal multiply on the running magnitude) and by
// how fast the response side takes characters. The result register lets a new
// item be accepted while the last character of the previous one is still
// waiting.
`default_nettype none

module integer_to_padded_decimal_text #(
   parameter int MAX_DIGITS = itpdt_pkg::MAX_DIGITS_DEFAULT
) (
   input wire logic    clock,
   input wire logic    reset,
   itpdt_req_if.sink   req_if,
   itpdt_rsp_if.source rsp_if
);
   import itpdt_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // sequencing
   itpdt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // digit generation and result register
   itpdt_datapath #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_value       (req_if.value),
      .req_digit_count (req_if.digit_count),
      .req_sign_mode   (req_if.sign_mode),
      .rsp_valid       (rsp_if.valid),
      .rsp_ready       (rsp_if.ready),
      .rsp_character   (rsp_if.character),
      .rsp_position    (rsp_if.position),
      .rsp_final_char  (rsp_if.final_char)
   );

endmodule

`default_nettype wire

/* src/itpdt_checker.sv */
`default_nettype none

`include "integer_to_padded_decimal_text_macros.svh"

module itpdt_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_ready,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic [itpdt_pkg::CHAR_W-1:0]  character,
   input wire logic [itpdt_pkg::POS_W-1:0]   position,
   input wire logic                          final_char
);
   import itpdt_pkg::*;

   // a stalled character holds
   `ITPDT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(character) && $stable(position) && $stable(final_char), "stalled item changed")

   // no second item while one is being formatted
   `ITPDT_ASSERT_NEXT(a_busy_after_load, clock, reset, req_valid && req_ready, !req_ready, "ready right after accept")

   // positions count down without gaps
   `ITPDT_ASSERT_NEXT(a_pos_step, clock, reset, rsp_valid && rsp_ready && !final_char, rsp_valid && (position == $past(position) - 5'd1), "position not consecutive")

   // only digits, minus or space, and the last one is at position 0
   `ITPDT_ASSERT_NOW(a_char_set, clock, reset, rsp_valid, ((character >= CH_ZERO) && (character <= CH_NINE)) || (character == CH_MINUS) || (character == CH_SPACE), "illegal character")
   `ITPDT_ASSERT_NOW(a_final_pos, clock, reset, rsp_valid && final_char, position == '0, "final item not at position 0")

endmodule

bind integer_to_padded_decimal_text itpdt_checker u_itpdt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_if.valid),
   .req_ready  (req_if.ready),
   .rsp_valid  (rsp_if.valid),
   .rsp_ready  (rsp_if.ready),
   .character  (rsp_if.character),
   .position   (rsp_if.position),
   .final_char (rsp_if.final_char)
);

`default_nettype wire
